// ----- hw/rtl/mplm_pkg.sv -----
package mplm_pkg;

    localparam int NUM_PATTERNS_DEF = 16;
    localparam int PATTERN_LEN_DEF  = 32;

    localparam int POS_W  = 6;
    localparam int LPOS_W = 7;
    localparam int CNT_W  = 32;

    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_EOL  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_IGNORE_CASE   = 2'd0,
        REG_EXACT_LINE    = 2'd1,
        REG_INVERT_SENSE  = 2'd2,
        REG_PATTERN_COUNT = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic              load;
        logic              text;
        logic [3:0]        idx;
        logic [POS_W-1:0]  pos;
        logic [7:0]        chr;
        logic              pat_end;
        logic [LPOS_W-1:0] line_pos;
        logic              ignore_case;
        logic              exact_line;
        logic [4:0]        count;
    } t_cell_ctl;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && c >= UPPER_A && c <= UPPER_Z) begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/mplm_cell.sv -----
module mplm_cell #(
    parameter int INDEX       = 0,
    parameter int PATTERN_LEN = mplm_pkg::PATTERN_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mplm_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_sweep,
    input  logic                 i_hit,
    output logic                 o_sweep,
    output logic                 o_hit
);

    localparam int IW = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
    localparam int LW = $clog2(PATTERN_LEN + 1);
    localparam int LPOS_W_L = mplm_pkg::LPOS_W;

    logic [7:0]             r_chars [PATTERN_LEN];
    logic [LW-1:0]          r_len;
    logic [PATTERN_LEN-1:0] r_pm;
    logic                   r_found;
    logic                   r_eqsf;
    logic                   r_sweep;
    logic                   r_hit;

    logic [PATTERN_LEN-1:0] eqv;
    logic [PATTERN_LEN-1:0] lastmask;
    logic [PATTERN_LEN-1:0] n_pm;
    logic                   found_now;
    logic                   pos_miss;
    logic                   my_hit;
    logic                   in_use;
    logic                   load_me;
    logic [LPOS_W_L-1:0]    len_ext;

    assign len_ext = LPOS_W_L'(r_len);
    assign load_me = i_ctl.load && (INDEX < 16) && (32'(i_ctl.idx) == INDEX);
    assign in_use  = 32'(i_ctl.count) > INDEX;

    always_comb begin
        for (int k = 0; k < PATTERN_LEN; k++) begin
            eqv[k] = (mplm_pkg::fold(r_chars[k], i_ctl.ignore_case) == i_ctl.chr)
                && (k < 32'(r_len));
            lastmask[k] = (k + 1 == 32'(r_len));
        end
        n_pm      = ((r_pm << 1) | PATTERN_LEN'(1)) & eqv;
        found_now = |(n_pm & lastmask);
        pos_miss  = (i_ctl.line_pos >= len_ext) ||
            (mplm_pkg::fold(r_chars[i_ctl.line_pos[IW-1:0]], i_ctl.ignore_case)
                != i_ctl.chr);
        if (i_ctl.exact_line) begin
            my_hit = r_eqsf && (i_ctl.line_pos == len_ext);
        end else begin
            my_hit = (r_len == '0) || r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_me) begin
            r_chars[i_ctl.pos[IW-1:0]] <= i_ctl.chr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_pm    <= '0;
            r_found <= 1'b0;
            r_eqsf  <= 1'b1;
            r_sweep <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_sweep <= i_sweep;
            if (i_sweep) begin
                r_hit   <= i_hit || (in_use && my_hit);
                r_pm    <= '0;
                r_found <= 1'b0;
                r_eqsf  <= 1'b1;
            end else if (i_ctl.text) begin
                r_pm <= n_pm;
                if (found_now) begin
                    r_found <= 1'b1;
                end
                if (pos_miss) begin
                    r_eqsf <= 1'b0;
                end
            end
            if (load_me && i_ctl.pat_end) begin
                r_len <= LW'(32'(i_ctl.pos) + 1);
            end
        end
    end

    assign o_sweep = r_sweep;
    assign o_hit   = r_hit;

endmodule

// ----- hw/rtl/multi_pattern_line_matcher.sv -----
// Load and text-byte transactions may follow back to back.
// An end-of-line transaction starts a sweep that walks the row of pattern cells,
// one cell per cycle; the result is registered as the sweep leaves the last cell.
// No input is accepted during the sweep or while a result waits to be taken.
// Synchronous active-low reset clears lengths, line state, counters and the
// configuration registers; pattern bytes and result registers are not reset.
module multi_pattern_line_matcher #(
    parameter int NUM_PATTERNS = mplm_pkg::NUM_PATTERNS_DEF,
    parameter int PATTERN_LEN  = mplm_pkg::PATTERN_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_pattern_index,
    input  logic [4:0]  i_char_pos,
    input  logic [7:0]  i_char_value,
    input  logic        i_pattern_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_line_selected,
    output logic [31:0] o_line_number,
    output logic [31:0] o_selected_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int LPW = mplm_pkg::LPOS_W;
    localparam int CW  = mplm_pkg::CNT_W;

    logic            r_ic, r_exact, r_inv;
    logic [4:0]      r_count;
    logic [LPW-1:0]  r_line_pos;
    logic            r_after_zero;
    logic [CW-1:0]   r_line_cnt, r_sel_cnt;
    logic            r_busy, r_start, r_out_valid, r_out_sel;
    logic [CW-1:0]   r_out_line, r_out_cnt;

    logic                 acc;
    logic                 text_go;
    logic                 sel;
    logic [4:0]           count_eff;
    mplm_pkg::t_cell_ctl  ctl;
    logic [NUM_PATTERNS:0] sweep_c, hit_c;

    assign o_ready     = !r_busy && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign acc         = i_valid && o_ready;
    assign text_go     = acc && (mplm_pkg::t_opcode'(i_opcode) == mplm_pkg::OP_TEXT)
        && !r_after_zero && (i_char_value != 8'd0);
    assign count_eff   = (32'(r_count) > NUM_PATTERNS) ? 5'(NUM_PATTERNS) : r_count;

    always_comb begin
        ctl.load        = acc && (mplm_pkg::t_opcode'(i_opcode) == mplm_pkg::OP_LOAD)
            && (32'(i_char_pos) < PATTERN_LEN);
        ctl.text        = text_go;
        ctl.idx         = i_pattern_index;
        ctl.pos         = mplm_pkg::POS_W'(i_char_pos);
        ctl.chr         = ctl.load ? i_char_value : mplm_pkg::fold(i_char_value, r_ic);
        ctl.pat_end     = i_pattern_end;
        ctl.line_pos    = r_line_pos;
        ctl.ignore_case = r_ic;
        ctl.exact_line  = r_exact;
        ctl.count       = count_eff;
    end

    assign sweep_c[0] = r_start;
    assign hit_c[0]   = 1'b0;

    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_cell
        mplm_cell #(
            .INDEX       (g),
            .PATTERN_LEN (PATTERN_LEN)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_sweep (sweep_c[g]),
            .i_hit   (hit_c[g]),
            .o_sweep (sweep_c[g+1]),
            .o_hit   (hit_c[g+1])
        );
    end

    assign sel = hit_c[NUM_PATTERNS] ^ r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic         <= 1'b0;
            r_exact      <= 1'b0;
            r_inv        <= 1'b0;
            r_count      <= '0;
            r_line_pos   <= '0;
            r_after_zero <= 1'b0;
            r_line_cnt   <= CW'(1);
            r_sel_cnt    <= '0;
            r_busy       <= 1'b0;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (mplm_pkg::t_reg_index'(i_cfg_index))
                    mplm_pkg::REG_IGNORE_CASE:   r_ic    <= i_cfg_data[0];
                    mplm_pkg::REG_EXACT_LINE:    r_exact <= i_cfg_data[0];
                    mplm_pkg::REG_INVERT_SENSE:  r_inv   <= i_cfg_data[0];
                    mplm_pkg::REG_PATTERN_COUNT: r_count <= i_cfg_data;
                    default: ;
                endcase
            end
            r_start <= 1'b0;
            if (acc && (mplm_pkg::t_opcode'(i_opcode) == mplm_pkg::OP_TEXT)
                && !r_after_zero && (i_char_value == 8'd0)) begin
                r_after_zero <= 1'b1;
            end
            if (text_go && (32'(r_line_pos) < PATTERN_LEN + 1)) begin
                r_line_pos <= r_line_pos + LPW'(1);
            end
            if (acc && (mplm_pkg::t_opcode'(i_opcode) == mplm_pkg::OP_EOL)) begin
                r_busy  <= 1'b1;
                r_start <= 1'b1;
            end
            if (sweep_c[NUM_PATTERNS]) begin
                r_busy       <= 1'b0;
                r_out_valid  <= 1'b1;
                r_line_pos   <= '0;
                r_after_zero <= 1'b0;
                if (r_line_cnt != '1) begin
                    r_line_cnt <= r_line_cnt + CW'(1);
                end
                if (sel && r_sel_cnt != '1) begin
                    r_sel_cnt <= r_sel_cnt + CW'(1);
                end
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sweep_c[NUM_PATTERNS]) begin
            r_out_sel  <= sel;
            r_out_line <= r_line_cnt;
            r_out_cnt  <= (sel && r_sel_cnt != '1) ? r_sel_cnt + CW'(1) : r_sel_cnt;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_line_selected  = r_out_sel;
    assign o_line_number    = r_out_line;
    assign o_selected_count = r_out_cnt;

    a_rise_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(sweep_c[NUM_PATTERNS]))
        else $error("result appeared without a finished sweep");

    a_line_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_cnt != '0)
        else $error("line counter reached zero");

    a_result_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_busy)
        else $error("result pending while sweep in progress");

endmodule
